/* rtl/skst_pkg.sv */
`timescale 1ns / 1ps

package skst_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int KEY_IN_W     = 32;
	localparam int CMD_W        = 2;

	// command codes; the unused code behaves as a lookup
	localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INS_ABSENT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INS_ALWAYS = 2'd2;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SEARCH
	} skst_state_t;

	// per-cell update control
	typedef struct packed {
		logic shift;
		logic load;
	} skst_cell_ctl_t;

	// per-cell compare result, broadcast key against held entry
	typedef struct packed {
		logic lt;
		logic eq;
	} skst_flag_t;

endpackage

/* rtl/skst_cell.sv */
`timescale 1ns / 1ps

module skst_cell #(
	parameter int KEY_BITS = skst_pkg::KEY_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    key_signed,
	input  logic                    sample,
	input  logic [KEY_BITS-1:0]     probe_key,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [KEY_BITS-1:0]     left_key,
	input  skst_pkg::skst_cell_ctl_t ctl,
	output logic [KEY_BITS-1:0]     entry,
	output skst_pkg::skst_flag_t    flag
);

	logic [KEY_BITS-1:0]  entry_q;
	logic [KEY_BITS-1:0]  kv;
	logic [KEY_BITS-1:0]  ev;
	skst_pkg::skst_flag_t flag_q;

	// signed order: flip the sign bit, then compare unsigned
	always_comb begin
		kv = probe_key;
		ev = entry_q;
		kv[KEY_BITS-1] = probe_key[KEY_BITS-1] ^ key_signed;
		ev[KEY_BITS-1] = entry_q[KEY_BITS-1] ^ key_signed;
	end

	// entry contents need no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_key;
		end else if (ctl.shift) begin
			entry_q <= left_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
		end else if (sample) begin
			flag_q.lt <= (kv < ev);
			flag_q.eq <= (kv == ev);
		end
	end

	assign entry = entry_q;
	assign flag  = flag_q;

endmodule

/* rtl/skst_search.sv */
`timescale 1ns / 1ps

module skst_search #(
	parameter int CAPACITY = skst_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = skst_pkg::KEY_BITS_DEF,
	localparam int CNT_W   = $clog2(CAPACITY + 1),
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [skst_pkg::CMD_W-1:0] in_cmd,
	input  logic [KEY_BITS-1:0]        in_key,
	input  logic [CAPACITY-1:0]        lt_vec,
	input  logic [CAPACITY-1:0]        eq_vec,
	output logic                       ins_en,
	output logic [IDX_W-1:0]           ins_pos,
	output logic [KEY_BITS-1:0]        ins_key,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [CNT_W-1:0]           out_position,
	output logic                       out_found,
	output logic                       out_inserted,
	output logic                       out_full_res,
	output logic [CNT_W-1:0]           out_entry_total
);

	skst_pkg::skst_state_t       state_q, state_d;
	logic [CNT_W-1:0]            lo_q, lo_d, hi_q, hi_d, count_q, count_d;
	logic [skst_pkg::CMD_W-1:0]  cmd_q;
	logic [KEY_BITS-1:0]         key_q;
	logic                        out_valid_q, out_valid_d;
	logic [CNT_W-1:0]            pos_q, total_q;
	logic                        found_q, ins_q, full_q;

	logic [CNT_W-1:0] diff, mid, pos;
	logic [IDX_W-1:0] mid_idx;
	logic             open, hit, done, want, full, ins, commit;

	always_comb begin
		diff    = hi_q - lo_q;
		mid     = lo_q + (diff >> 1);
		mid_idx = mid[IDX_W-1:0];
		open    = (lo_q < hi_q);
		hit     = open && eq_vec[mid_idx];
		done    = !open || hit;
		pos     = hit ? mid : lo_q;
		want    = (cmd_q == skst_pkg::CMD_INS_ALWAYS) ||
		          ((cmd_q == skst_pkg::CMD_INS_ABSENT) && !hit);
		full    = want && (count_q >= CNT_W'(CAPACITY));
		ins     = want && !full;
	end

	always_comb begin
		state_d     = state_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		count_d     = count_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		commit      = 1'b0;
		unique case (state_q)
			skst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					lo_d    = '0;
					hi_d    = count_q;
					state_d = skst_pkg::ST_SEARCH;
				end
			end
			skst_pkg::ST_SEARCH: begin
				if (done) begin
					// hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						commit      = 1'b1;
						out_valid_d = 1'b1;
						count_d     = count_q + CNT_W'(ins);
						state_d     = skst_pkg::ST_IDLE;
					end
				end else if (lt_vec[mid_idx]) begin
					hi_d = mid;
				end else begin
					lo_d = mid + CNT_W'(1);
				end
			end
			default: state_d = skst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skst_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			lo_q        <= lo_d;
			hi_q        <= hi_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
		end
		if (commit) begin
			pos_q   <= pos;
			found_q <= hit;
			ins_q   <= ins;
			full_q  <= full;
			total_q <= count_d;
		end
	end

	assign ins_en          = commit && ins;
	assign ins_pos         = pos[IDX_W-1:0];
	assign ins_key         = key_q;
	assign out_valid       = out_valid_q;
	assign out_position    = pos_q;
	assign out_found       = found_q;
	assign out_inserted    = ins_q;
	assign out_full_res    = full_q;
	assign out_entry_total = total_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |-> (count_q < CNT_W'(CAPACITY)) && (pos <= count_q))
		else $error("insert without room or past the count");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("count not bumped by insert");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skst_pkg::ST_SEARCH) |-> (lo_q <= hi_q) && (hi_q <= count_q))
		else $error("search window out of order");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!ins_en && state_q == skst_pkg::ST_IDLE) |=> count_q == $past(count_q))
		else $error("count moved without an insert");

endmodule

/* rtl/sorted_key_set_table.sv */
`timescale 1ns / 1ps

// Sorted key table: holds up to CAPACITY keys in ascending order (unsigned,
// or two's complement once key_signed is written as 1) in a row of cells.
// Each input word carries a command in s_tuser and a key in s_tdata; each
// one gives exactly one result word. Lookups report the position found by a
// halving probe (stopping at the first equal probe, otherwise the lower
// bound) and whether the key was met; inserts put the key at that position
// and every cell above takes its lower neighbour's key in the same cycle.
// An item is taken in the idle state and then runs the probe loop, which
// reads one cell's registered compare flags per probe until a probe hits or
// the window is empty; the commit waits while the output register is full.
// The next word is taken once the current one has been committed, even
// while its result still waits in the output register.
// Entries at or above the count are never probed, so no clearing is needed.

module sorted_key_set_table #(
	parameter int CAPACITY  = skst_pkg::CAPACITY_DEF,
	parameter int KEY_BITS  = skst_pkg::KEY_BITS_DEF,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int IDX_W    = $clog2(CAPACITY),
	localparam int RES_W    = 2 * CNT_W + 3,
	localparam int M_DATA_W = ((RES_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration: bit 0 = key_signed
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	// input words
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [skst_pkg::KEY_IN_W-1:0] s_tdata, // key
	input  logic [skst_pkg::CMD_W-1:0] s_tuser,   // cmd
	// result words
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// position, found, inserted, full_res, entry_total, zero padding
	output logic [M_DATA_W-1:0]        m_tdata
);

	logic                 key_signed_q;
	logic [KEY_BITS-1:0]  in_key;
	logic                 accept;
	logic [CAPACITY-1:0]  lt_vec, eq_vec;
	logic                 ins_en;
	logic [IDX_W-1:0]     ins_pos;
	logic [KEY_BITS-1:0]  ins_key;
	logic [KEY_BITS-1:0]  entries [CAPACITY];
	skst_pkg::skst_flag_t flags   [CAPACITY];
	logic [CNT_W-1:0]     res_pos, res_total;
	logic                 res_found, res_ins, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_signed_q <= 1'b0;
		end else if (cfg_valid) begin
			key_signed_q <= cfg_data;
		end
	end

	// only the low KEY_BITS bits of the key word count
	assign in_key = KEY_BITS'(s_tdata);
	assign accept = s_tvalid && s_tready;

	skst_search #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_search (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_cmd          (s_tuser),
		.in_key          (in_key),
		.lt_vec          (lt_vec),
		.eq_vec          (eq_vec),
		.ins_en          (ins_en),
		.ins_pos         (ins_pos),
		.ins_key         (ins_key),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_position    (res_pos),
		.out_found       (res_found),
		.out_inserted    (res_ins),
		.out_full_res    (res_full),
		.out_entry_total (res_total)
	);

	// the chain: cell i loads the new key at the insert position and takes
	// cell i-1's key above it; cell 0 never shifts
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skst_pkg::skst_cell_ctl_t ctl;
		logic [KEY_BITS-1:0]      left_key;

		assign ctl.load  = ins_en && (ins_pos == IDX_W'(i));
		assign ctl.shift = ins_en && (ins_pos < IDX_W'(i));
		if (i == 0) begin : g_first
			assign left_key = ins_key;
		end else begin : g_rest
			assign left_key = entries[i-1];
		end

		skst_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.key_signed (key_signed_q),
			.sample     (accept),
			.probe_key  (in_key),
			.new_key    (ins_key),
			.left_key   (left_key),
			.ctl        (ctl),
			.entry      (entries[i]),
			.flag       (flags[i])
		);

		assign lt_vec[i] = flags[i].lt;
		assign eq_vec[i] = flags[i].eq;
	end

	assign m_tdata = M_DATA_W'({res_total, res_full, res_ins, res_found, res_pos});

endmodule
